// ===== rtl/psa_pkg.sv =====
// Package for the pooled slot allocator: widths, codes and reset values.
// No dependencies; imported by the interfaces and the top module.
package psa_pkg;

   localparam int MAX_CHUNKS  = 16;
   localparam int ITEMS_MAX   = 16;
   localparam int ITEM_BITS   = 4;
   localparam int CHUNK_BITS  = 4;
   localparam int HANDLE_W    = 8;
   localparam int SLOT_TOTAL  = MAX_CHUNKS * ITEMS_MAX;
   localparam int CNT_W       = 5;
   localparam int BUSY_W      = 5;
   localparam int FREE_W      = 9;
   localparam int COUNT16_W   = 16;
   localparam int REQ_BYTES_W = 16;
   localparam int SLOT_BYTES_W = 13;
   localparam int CHUNK_ITEMS_W = 5;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_BYTES  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_ITEMS = 1'd1;

   localparam logic [SLOT_BYTES_W-1:0]  SLOT_BYTES_RESET  = 13'd64;
   localparam logic [CHUNK_ITEMS_W-1:0] CHUNK_ITEMS_RESET = 5'd10;

   typedef logic [1:0] action_type;
   localparam action_type ACT_ALLOC   = 2'd0;
   localparam action_type ACT_FREE    = 2'd1;
   localparam action_type ACT_RELEASE = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK           = 2'd0;
   localparam status_type ST_NO_MEMORY    = 2'd1;
   localparam status_type ST_NOT_ALL_FREE = 2'd2;

endpackage

// ===== rtl/psa_req_if.sv =====
// Request channel of the pooled slot allocator: valid/ready plus fields.
// Depends on psa_pkg.
interface psa_req_if import psa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   action_type             action;
   logic [REQ_BYTES_W-1:0] request_bytes;
   logic [HANDLE_W-1:0]    free_handle;
   logic                   free_is_oversize;

   modport source (output valid, action, request_bytes, free_handle, free_is_oversize,
                   input ready);
   modport sink   (input valid, action, request_bytes, free_handle, free_is_oversize,
                   output ready);
endinterface

// ===== rtl/psa_rsp_if.sv =====
// Response channel of the pooled slot allocator: valid/ready plus fields.
// Depends on psa_pkg.
interface psa_rsp_if import psa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [HANDLE_W-1:0]  slot_handle;
   logic                 slot_oversize;
   logic [BUSY_W-1:0]    chunk_in_use;
   logic [COUNT16_W-1:0] allocated_count;
   logic [FREE_W-1:0]    free_slots;
   logic [CNT_W-1:0]     chunks_held;
   logic [COUNT16_W-1:0] oversize_total;

   modport source (output valid, status, slot_handle, slot_oversize, chunk_in_use,
                   allocated_count, free_slots, chunks_held, oversize_total,
                   input ready);
   modport sink   (input valid, status, slot_handle, slot_oversize, chunk_in_use,
                   allocated_count, free_slots, chunks_held, oversize_total,
                   output ready);
endinterface

// ===== rtl/psa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module psa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ===== rtl/pooled_slot_allocator_top.sv =====
// Sequencing: free, release, oversize and refused requests answer from EXEC; a pooled
// allocate or free answers from POP or PUSH; an allocate that adds a chunk first passes
// through GROW, one link write per new slot for n slots (n being the clamped chunk_items).
// Throughput: one request at a time; the next is taken once the response is registered.
// Reset: synchronous, clears the pool (no chunks, empty list, zero counters) and the
// registers to their defaults; the link and busy memories are not cleared.
// Depends on psa_pkg, psa_req_if, psa_rsp_if and psa_ram.
module pooled_slot_allocator_top import psa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   psa_req_if.sink                 req_bus,
   psa_rsp_if.source               rsp_bus
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_GROW = 3'd2;
   localparam logic [2:0] S_POP  = 3'd3;
   localparam logic [2:0] S_PUSH = 3'd4;

   logic [2:0]               state_ff, state_in;
   action_type               act_ff;
   logic [REQ_BYTES_W-1:0]   req_bytes_ff;
   logic [HANDLE_W-1:0]      fh_ff;
   logic                     fover_ff;
   logic [SLOT_BYTES_W-1:0]  slot_bytes_ff;
   logic [CHUNK_ITEMS_W-1:0] chunk_items_ff;

   logic [HANDLE_W-1:0]      head_ff, head_in;
   logic                     nonempty_ff, nonempty_in;
   logic [CNT_W-1:0]         chunk_total_ff, chunk_total_in;
   logic [COUNT16_W-1:0]     outstanding_ff, outstanding_in;
   logic [FREE_W-1:0]        free_total_ff, free_total_in;
   logic [COUNT16_W-1:0]     oversize_ff, oversize_in;
   logic [CNT_W-1:0]         busy_cnt_ff, busy_cnt_in;
   logic [ITEM_BITS-1:0]     grow_idx_ff, grow_idx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]      rsp_handle_ff, rsp_handle_in;
   logic                     rsp_over_ff, rsp_over_in;
   logic [BUSY_W-1:0]        rsp_in_use_ff, rsp_in_use_in;
   logic [COUNT16_W-1:0]     rsp_alloc_ff;
   logic [FREE_W-1:0]        rsp_free_ff;
   logic [CNT_W-1:0]         rsp_chunks_ff;
   logic [COUNT16_W-1:0]     rsp_oversize_ff;

   logic                     link_we, link_re;
   logic [HANDLE_W-1:0]      link_waddr, link_wdata, link_raddr, link_rdata;
   logic                     busy_we, busy_re;
   logic [CHUNK_BITS-1:0]    busy_waddr, busy_raddr;
   logic [BUSY_W-1:0]        busy_wdata, busy_rdata;

   logic                     fin, out_free, fits, grow_last, free_held;
   logic [SLOT_BYTES_W:0]    limit;
   logic [CNT_W-1:0]         n_items;
   logic [HANDLE_W-1:0]      grow_handle;
   logic [BUSY_W-1:0]        busy_new;

   psa_ram #(.WIDTH(HANDLE_W), .DEPTH(SLOT_TOTAL)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   psa_ram #(.WIDTH(BUSY_W), .DEPTH(MAX_CHUNKS)) u_busy_ram (
      .clock (clock),
      .we    (busy_we),
      .waddr (busy_waddr),
      .wdata (busy_wdata),
      .re    (busy_re),
      .raddr (busy_raddr),
      .rdata (busy_rdata)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign limit       = ({1'b0, slot_bytes_ff} + (SLOT_BYTES_W+1)'(7)) &
                        ~(SLOT_BYTES_W+1)'(7);
   assign fits        = req_bytes_ff <= REQ_BYTES_W'(limit);
   assign n_items     = (chunk_items_ff == '0) ? CNT_W'(1) :
                        (chunk_items_ff > CNT_W'(ITEMS_MAX)) ? CNT_W'(ITEMS_MAX) :
                        chunk_items_ff;
   assign grow_last   = ({1'b0, grow_idx_ff} == n_items - CNT_W'(1));
   assign grow_handle = {chunk_total_ff[CHUNK_BITS-1:0], grow_idx_ff};
   assign free_held   = {1'b0, fh_ff[HANDLE_W-1:ITEM_BITS]} < chunk_total_ff;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      nonempty_in    = nonempty_ff;
      chunk_total_in = chunk_total_ff;
      outstanding_in = outstanding_ff;
      free_total_in  = free_total_ff;
      oversize_in    = oversize_ff;
      busy_cnt_in    = busy_cnt_ff;
      grow_idx_in    = grow_idx_ff;
      fin            = 1'b0;
      rsp_status_in  = ST_OK;
      rsp_handle_in  = '0;
      rsp_over_in    = 1'b0;
      rsp_in_use_in  = '0;
      link_we        = 1'b0;
      link_waddr     = grow_handle;
      link_wdata     = head_ff;
      link_re        = 1'b0;
      link_raddr     = head_ff;
      busy_we        = 1'b0;
      busy_waddr     = chunk_total_ff[CHUNK_BITS-1:0];
      busy_wdata     = '0;
      busy_re        = 1'b0;
      busy_raddr     = head_ff[HANDLE_W-1:ITEM_BITS];
      busy_new       = busy_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (act_ff)
               ACT_ALLOC: begin
                  if (!nonempty_ff) begin
                     if (chunk_total_ff >= CNT_W'(MAX_CHUNKS)) begin
                        if (out_free) begin
                           fin           = 1'b1;
                           rsp_status_in = ST_NO_MEMORY;
                           state_in      = S_IDLE;
                        end
                     end else begin
                        grow_idx_in = '0;
                        state_in    = S_GROW;
                     end
                  end else if (fits) begin
                     link_re  = 1'b1;
                     busy_re  = 1'b1;
                     state_in = S_POP;
                  end else if (out_free) begin
                     if (outstanding_ff != '1) outstanding_in = outstanding_ff + 1'b1;
                     if (oversize_ff != '1) oversize_in = oversize_ff + 1'b1;
                     rsp_over_in = 1'b1;
                     fin         = 1'b1;
                     state_in    = S_IDLE;
                  end
               end
               ACT_FREE: begin
                  if (fover_ff) begin
                     if (out_free) begin
                        if (outstanding_ff != '0) outstanding_in = outstanding_ff - 1'b1;
                        fin      = 1'b1;
                        state_in = S_IDLE;
                     end
                  end else if (free_held) begin
                     busy_re    = 1'b1;
                     busy_raddr = fh_ff[HANDLE_W-1:ITEM_BITS];
                     state_in   = S_PUSH;
                  end else if (out_free) begin
                     fin      = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               ACT_RELEASE: begin
                  if (out_free) begin
                     if (busy_cnt_ff == '0) begin
                        chunk_total_in = '0;
                        free_total_in  = '0;
                        nonempty_in    = 1'b0;
                        head_in        = '0;
                     end else begin
                        rsp_status_in = ST_NOT_ALL_FREE;
                     end
                     fin      = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     fin      = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_GROW: begin
            link_we     = 1'b1;
            head_in     = grow_handle;
            nonempty_in = 1'b1;
            if (free_total_ff != '1) free_total_in = free_total_ff + 1'b1;
            busy_we     = (grow_idx_ff == '0);
            grow_idx_in = grow_idx_ff + 1'b1;
            if (grow_last) begin
               chunk_total_in = chunk_total_ff + 1'b1;
               state_in       = S_EXEC;
            end
         end
         S_POP: begin
            if (out_free) begin
               busy_new = (busy_rdata != '1) ? busy_rdata + 1'b1 : busy_rdata;
               busy_we    = 1'b1;
               busy_waddr = head_ff[HANDLE_W-1:ITEM_BITS];
               busy_wdata = busy_new;
               if (busy_rdata == '0) busy_cnt_in = busy_cnt_ff + 1'b1;
               head_in = link_rdata;
               if (free_total_ff != '0) free_total_in = free_total_ff - 1'b1;
               nonempty_in = (free_total_in != '0);
               if (outstanding_ff != '1) outstanding_in = outstanding_ff + 1'b1;
               rsp_handle_in = head_ff;
               rsp_in_use_in = busy_new;
               fin           = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_PUSH: begin
            if (out_free) begin
               busy_new = (busy_rdata != '0) ? busy_rdata - 1'b1 : busy_rdata;
               busy_we    = 1'b1;
               busy_waddr = fh_ff[HANDLE_W-1:ITEM_BITS];
               busy_wdata = busy_new;
               if (busy_rdata == BUSY_W'(1)) busy_cnt_in = busy_cnt_ff - 1'b1;
               link_we     = 1'b1;
               link_waddr  = fh_ff;
               head_in     = fh_ff;
               nonempty_in = 1'b1;
               if (free_total_ff != '1) free_total_in = free_total_ff + 1'b1;
               if (outstanding_ff != '0) outstanding_in = outstanding_ff - 1'b1;
               rsp_in_use_in = busy_new;
               fin           = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         slot_bytes_ff  <= SLOT_BYTES_RESET;
         chunk_items_ff <= CHUNK_ITEMS_RESET;
         head_ff        <= '0;
         nonempty_ff    <= 1'b0;
         chunk_total_ff <= '0;
         outstanding_ff <= '0;
         free_total_ff  <= '0;
         oversize_ff    <= '0;
         busy_cnt_ff    <= '0;
         grow_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         nonempty_ff    <= nonempty_in;
         chunk_total_ff <= chunk_total_in;
         outstanding_ff <= outstanding_in;
         free_total_ff  <= free_total_in;
         oversize_ff    <= oversize_in;
         busy_cnt_ff    <= busy_cnt_in;
         grow_idx_ff    <= grow_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SLOT_BYTES:  slot_bytes_ff  <= csr_wdata[SLOT_BYTES_W-1:0];
               CSR_CHUNK_ITEMS: chunk_items_ff <= csr_wdata[CHUNK_ITEMS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         act_ff       <= req_bus.action;
         req_bytes_ff <= req_bus.request_bytes;
         fh_ff        <= req_bus.free_handle;
         fover_ff     <= req_bus.free_is_oversize;
      end
      if (fin) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_handle_ff   <= rsp_handle_in;
         rsp_over_ff     <= rsp_over_in;
         rsp_in_use_ff   <= rsp_in_use_in;
         rsp_alloc_ff    <= outstanding_in;
         rsp_free_ff     <= free_total_in;
         rsp_chunks_ff   <= chunk_total_in;
         rsp_oversize_ff <= oversize_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.slot_handle     = rsp_handle_ff;
   assign rsp_bus.slot_oversize   = rsp_over_ff;
   assign rsp_bus.chunk_in_use    = rsp_in_use_ff;
   assign rsp_bus.allocated_count = rsp_alloc_ff;
   assign rsp_bus.free_slots      = rsp_free_ff;
   assign rsp_bus.chunks_held     = rsp_chunks_ff;
   assign rsp_bus.oversize_total  = rsp_oversize_ff;

`ifndef SYNTHESIS
   a_link_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(link_we && link_re))
      else $error("link memory read and write in the same cycle");

   a_busy_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_cnt_ff <= chunk_total_ff)
      else $error("more busy chunks than chunks held");

   a_grow_has_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GROW |-> chunk_total_ff < CNT_W'(MAX_CHUNKS))
      else $error("chunk added beyond the chunk limit");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> state_ff == S_EXEC)
      else $error("accepted request not dispatched");
`endif

endmodule
